/* src/pcl_pkg.sv */
package pcl_pkg;

    // Default number of character cells.
    localparam int PCL_CAPACITY = 32;

    // Fixed field widths.
    localparam int POS_W  = 6;
    localparam int CHAR_W = 8;

    // Operation codes carried on the cmd field.
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_PRINT  = 2'd3
    } cmd_t;

    // Result kinds carried on the kind field.
    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_EOL     = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_in;
        logic  do_insert;
        logic  do_delete;
        logic  idx_clear;
        logic  idx_inc;
        logic  sel_print;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
    } pcl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t op;
        logic add_ok;
        logic rank_ok;
        logic idx_done;
        logic out_free;
    } pcl_status_t;

endpackage

/* src/positional_char_list_unit.sv */
// Ordered byte list with insert, delete and read at a 1-based rank.
// Add and delete: the item is accepted, then the cells shift in parallel.
// Get and invalid rank: the result sits in the output register.
// Print: one result per cycle from the shared read port, while the output is not stalled.
// Output stalls hold the controller; reset clears count, index, valid flag and state.
// Reset (rst_n, asynchronous, active low) empties the list; cell contents are not cleared.
module positional_char_list_unit #(
    parameter int CAPACITY = pcl_pkg::PCL_CAPACITY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 cmd,
    input  logic [pcl_pkg::POS_W-1:0]  position,
    input  logic [pcl_pkg::CHAR_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic [pcl_pkg::CHAR_W-1:0] char_out,
    output logic                       last
);
    import pcl_pkg::*;

    pcl_cmd_t    command;
    pcl_status_t status;

    // Sequencing of each item.
    pcl_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .command  (command)
    );

    // Cells, count and output register.
    pcl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .position  (position),
        .value     (value),
        .command   (command),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .char_out  (char_out),
        .last      (last)
    );

endmodule

/* src/pcl_datapath.sv */
module pcl_datapath #(
    parameter int CAPACITY = pcl_pkg::PCL_CAPACITY
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                cmd,
    input  logic [pcl_pkg::POS_W-1:0] position,
    input  logic [pcl_pkg::CHAR_W-1:0] value,
    input  pcl_pkg::pcl_cmd_t         command,
    output pcl_pkg::pcl_status_t      status,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                kind,
    output logic [pcl_pkg::CHAR_W-1:0] char_out,
    output logic                      last
);
    import pcl_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = POS_W + 1;

    // Latched input item.
    cmd_t              op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CHAR_W-1:0] val_reg;

    // List count, print index and cells.
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0] cells_reg [CAPACITY];

    // Output register.
    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    logic [IDX_W-1:0]  rank_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic [CHAR_W-1:0] rd_char;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;

    // Capture the item on acceptance.
    always_ff @(posedge clk)
    begin
        if (command.load_in)
        begin
            op_reg  <= cmd_t'(cmd);
            pos_reg <= position;
            val_reg <= value;
        end
    end

    // Zero-based index of the addressed rank.
    assign rank_idx = IDX_W'(pos_reg - POS_W'(1));

    // Range checks on the rank.
    assign pos_x = CMP_W'(pos_reg);
    assign cnt_x = CMP_W'(count_reg);

    always_comb
    begin
        status.op       = op_reg;
        status.add_ok   = (pos_reg != '0) && (pos_x <= cnt_x + CMP_W'(1))
                          && (cnt_x < CMP_W'(CAPACITY));
        status.rank_ok  = (pos_reg != '0) && (pos_x <= cnt_x);
        status.idx_done = (idx_reg == count_reg);
        status.out_free = !out_valid_reg || out_ready;
    end

    // Each cell takes the new byte, its lower neighbour on insert, or its
    // upper neighbour on delete. Cells above the count carry no meaning.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [CHAR_W-1:0] lower;
        logic [CHAR_W-1:0] upper;

        if (g == 0)
        begin : g_first
            assign lower = cells_reg[g];
        end
        else
        begin : g_inner_lo
            assign lower = cells_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_top
            assign upper = cells_reg[g];
        end
        else
        begin : g_inner_hi
            assign upper = cells_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (command.do_insert && (IDX_W'(g) == rank_idx))
            begin
                cells_reg[g] <= val_reg;
            end
            else if (command.do_insert && (IDX_W'(g) > rank_idx))
            begin
                cells_reg[g] <= lower;
            end
            else if (command.do_delete && (IDX_W'(g) >= rank_idx))
            begin
                cells_reg[g] <= upper;
            end
        end
    end

    // Single read port shared by get and print.
    assign rd_addr = command.sel_print ? idx_reg[IDX_W-1:0] : rank_idx;
    assign rd_char = cells_reg[rd_addr];

    // Count and print index updates.
    always_comb
    begin
        count_next = count_reg;
        if (command.do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (command.do_delete)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        idx_next = idx_reg;
        if (command.idx_clear)
        begin
            idx_next = '0;
        end
        else if (command.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Output register: loaded on emit, emptied when the item is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (command.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (command.emit)
        begin
            kind_reg <= command.emit_kind;
            char_reg <= (command.emit_kind == KIND_CHAR) ? rd_char : '0;
            last_reg <= command.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

/* src/pcl_controller.sv */
module pcl_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pcl_pkg::pcl_status_t status,
    output pcl_pkg::pcl_cmd_t    command
);
    import pcl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECIDE = 3'b010,
        S_PRINT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next        = state_reg;
        command           = '0;
        command.emit_kind = KIND_CHAR;
        in_ready          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                command.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                unique case (status.op)
                    CMD_ADD:
                    begin
                        if (status.add_ok)
                        begin
                            command.do_insert = 1'b1;
                            state_next        = S_IDLE;
                        end
                        else if (status.out_free)
                        begin
                            command.emit      = 1'b1;
                            command.emit_kind = KIND_INVALID;
                            command.emit_last = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end

                    CMD_DELETE:
                    begin
                        if (status.rank_ok)
                        begin
                            command.do_delete = 1'b1;
                            state_next        = S_IDLE;
                        end
                        else if (status.out_free)
                        begin
                            command.emit      = 1'b1;
                            command.emit_kind = KIND_INVALID;
                            command.emit_last = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end

                    CMD_GET:
                    begin
                        if (status.out_free)
                        begin
                            command.emit      = 1'b1;
                            command.emit_kind = status.rank_ok ? KIND_CHAR : KIND_INVALID;
                            command.emit_last = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end

                    CMD_PRINT:
                    begin
                        command.idx_clear = 1'b1;
                        state_next        = S_PRINT;
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_PRINT:
            begin
                // Stream the stored bytes, then the end-of-line mark.
                command.sel_print = 1'b1;
                if (status.out_free)
                begin
                    command.emit = 1'b1;
                    if (status.idx_done)
                    begin
                        command.emit_kind = KIND_EOL;
                        command.emit_last = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        command.idx_inc = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/pcl_checker.sv */
module pcl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [1:0]                 cmd,
    input logic [pcl_pkg::POS_W-1:0]  position,
    input logic [pcl_pkg::CHAR_W-1:0] value,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 kind,
    input logic [pcl_pkg::CHAR_W-1:0] char_out,
    input logic                       last
);
    import pcl_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(char_out) && $stable(last))
        else $error("result changed while stalled");

    // Invalid and end-of-line results always close an item.
    a_nonchar_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_CHAR) |-> last)
        else $error("non-character result without last");

    // Only character results carry a byte.
    a_nonchar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_CHAR) |-> (char_out == '0))
        else $error("non-character result with a byte");

    // One item at a time: no acceptance in the cycle after an acceptance.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // While a print still has bytes to stream, no new item is taken.
    a_print_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("item accepted during print");

endmodule

bind positional_char_list_unit pcl_checker u_pcl_checker (.*);

/* dv/pcl_list_checker.sv */
`timescale 1ns / 100ps

module pcl_list_checker #(
    parameter int CAPACITY = pcl_pkg::PCL_CAPACITY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 cmd,
    input  logic [pcl_pkg::POS_W-1:0]  position,
    input  logic [pcl_pkg::CHAR_W-1:0] value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [1:0]                 kind,
    input  logic [pcl_pkg::CHAR_W-1:0] char_out,
    input  logic                       last,
    output int                         mismatches,
    output int                         awaited_count,
    output int                         stored_count
);

    import pcl_pkg::*;

    typedef struct {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } list_result_t;

    // Results still owed by the block, oldest first.
    list_result_t awaited_results[$];

    // Our own copy of the list contents, front of the queue is rank 1.
    logic [CHAR_W-1:0] held_chars[$];

    function automatic void owe_result(kind_t k, logic [CHAR_W-1:0] c, logic f);
        list_result_t r;
        r.kind = k;
        r.ch   = c;
        r.fin  = f;
        awaited_results.push_back(r);
    endfunction

    // Update the list copy for one accepted item and queue what it must produce.
    function automatic void apply_list_command(cmd_t op, logic [POS_W-1:0] rank,
                                               logic [CHAR_W-1:0] data);
        int n;
        int r;
        n = held_chars.size();
        r = int'(rank);
        case (op)
            CMD_PRINT:
            begin
                foreach (held_chars[i])
                    owe_result(KIND_CHAR, held_chars[i], 1'b0);
                owe_result(KIND_EOL, '0, 1'b1);
            end
            CMD_ADD:
            begin
                // A full list refuses any insert, whatever the rank.
                if (r == 0 || r > n + 1 || n >= CAPACITY)
                    owe_result(KIND_INVALID, '0, 1'b1);
                else
                    held_chars.insert(r - 1, data);
            end
            default:
            begin
                // Delete and get only reach ranks that hold a character.
                if (r == 0 || r > n)
                    owe_result(KIND_INVALID, '0, 1'b1);
                else if (op == CMD_GET)
                    owe_result(KIND_CHAR, held_chars[r - 1], 1'b1);
                else
                    held_chars.delete(r - 1);
            end
        endcase
    endfunction

    // Watch both channels on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            held_chars.delete();
            mismatches = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_list_command(cmd_t'(cmd), position, value);
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got kind %0d char %02h last %0b",
                             $time, kind, char_out, last);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (kind !== want.kind || char_out !== want.ch || last !== want.fin)
                    begin
                        mismatches++;
                        $display("%0t: result mismatch: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
                                 $time, want.kind, want.ch, want.fin, kind, char_out, last);
                    end
                end
            end
        end
        awaited_count = awaited_results.size();
        stored_count  = held_chars.size();
    end

endmodule

/* dv/positional_char_list_unit_test.sv */
`timescale 1ns / 100ps

module positional_char_list_unit_test;

    import pcl_pkg::*;

    localparam int RANDOM_ITEMS = 320;
    localparam int PHASE_LEN    = 60;

    // Kinds of random stretch: grow the list, churn it, shrink it.
    localparam int PHASE_FILL  = 0;
    localparam int PHASE_MIXED = 1;
    localparam int PHASE_DRAIN = 2;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    cmd_t              cmd;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] value;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic              last;

    int   mismatches;
    int   awaited_count;
    int   stored_count;
    logic squeeze_req;

    positional_char_list_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .char_out  (char_out),
        .last      (last)
    );

    pcl_list_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .char_out      (char_out),
        .last          (last),
        .mismatches    (mismatches),
        .awaited_count (awaited_count),
        .stored_count  (stored_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one item from a falling edge and hold it until it is taken.
    // Returns on the falling edge after acceptance.
    task automatic offer(input cmd_t op, input logic [POS_W-1:0] rank,
                         input logic [CHAR_W-1:0] data);
        in_valid <= 1'b1;
        cmd      <= op;
        position <= rank;
        value    <= data;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Sender gap with in_valid low; the idle payload carries junk.
    task automatic pause(input int n);
        in_valid <= 1'b0;
        cmd      <= cmd_t'($urandom_range(0, 3));
        position <= POS_W'($urandom_range(0, 63));
        value    <= CHAR_W'($urandom_range(0, 255));
        repeat (n) @(negedge clk);
    endtask

    // Pick one item, mostly with a rank that fits the current list length.
    task automatic offer_random(input int phase);
        int   roll;
        int   n;
        cmd_t op;
        logic [POS_W-1:0] rank;
        n    = stored_count;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL:
                op = roll < 80 ? CMD_ADD : roll < 86 ? CMD_DELETE :
                     roll < 94 ? CMD_GET : CMD_PRINT;
            PHASE_DRAIN:
                op = roll < 15 ? CMD_ADD : roll < 65 ? CMD_DELETE :
                     roll < 88 ? CMD_GET : CMD_PRINT;
            default:
                op = roll < 35 ? CMD_ADD : roll < 60 ? CMD_DELETE :
                     roll < 88 ? CMD_GET : CMD_PRINT;
        endcase
        if ($urandom_range(0, 9) < 2)
            rank = POS_W'($urandom_range(0, 63));
        else if (op == CMD_ADD)
            rank = POS_W'($urandom_range(1, n + 1));
        else
            rank = POS_W'($urandom_range(1, n == 0 ? 1 : n));
        offer(op, rank, CHAR_W'($urandom_range(0, 255)));
    endtask

    // Receiver: stretches of steady, random and sparse readiness,
    // plus one long hold-off when the sender asks for it.
    initial
    begin : receiver
        int   mode;
        int   span;
        logic squeezed;
        squeezed  = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(4, 40);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin : sender
        int   sent;
        int   burst;
        logic pressed;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_ADD;
        position    = '0;
        value       = '0;
        squeeze_req = 1'b0;
        pressed     = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners on an empty list first.
        offer(CMD_PRINT,  6'd0,  8'h00);
        offer(CMD_GET,    6'd0,  8'h00);
        offer(CMD_DELETE, 6'd0,  8'h00);
        offer(CMD_ADD,    6'd0,  8'h11);
        offer(CMD_GET,    6'd1,  8'h00);
        offer(CMD_DELETE, 6'd1,  8'h00);
        offer(CMD_ADD,    6'd2,  8'h22);
        // Build a short list: append, insert at the front, append at count+1.
        offer(CMD_ADD,    6'd1,  8'h00);
        offer(CMD_ADD,    6'd2,  8'hFF);
        offer(CMD_ADD,    6'd1,  8'hA5);
        offer(CMD_ADD,    6'd4,  8'h5A);
        offer(CMD_ADD,    6'd63, 8'h33);
        offer(CMD_GET,    6'd1,  8'h00);
        offer(CMD_GET,    6'd4,  8'h00);
        offer(CMD_GET,    6'd5,  8'h00);
        offer(CMD_DELETE, 6'd5,  8'h00);
        offer(CMD_GET,    6'd63, 8'h00);
        offer(CMD_DELETE, 6'd2,  8'h00);
        offer(CMD_PRINT,  6'd63, 8'hFF);
        offer(CMD_DELETE, 6'd3,  8'h00);
        offer(CMD_DELETE, 6'd1,  8'h00);
        offer(CMD_PRINT,  6'd0,  8'h00);

        // Random bursts, phased so the list both fills up and empties.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                offer_random((sent / PHASE_LEN) % 3);
                sent++;
            end
            // Once, stall the receiver while reads and prints keep coming.
            if (sent >= RANDOM_ITEMS / 2 && !pressed)
            begin
                pressed     = 1'b1;
                squeeze_req = 1'b1;
                for (int k = 0; k < 16; k++)
                    offer(k % 4 == 3 ? CMD_PRINT : CMD_GET,
                          POS_W'($urandom_range(1, stored_count == 0 ? 1 : stored_count)),
                          8'h00);
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        // Drain everything still owed, then allow a little settling time.
        while (awaited_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (mismatches == 0 && awaited_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
